// ===== rtl/pbrf_pkg.sv =====
// shared types, register map and bit masks of the bridge register file
package pbrf_pkg;

  localparam int MAP_WORDS = 16;
  localparam int WIN_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_DONE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [7:0] OFF_CTRL     = 8'h00;
  localparam logic [7:0] OFF_STATUS   = 8'h04;
  localparam logic [7:0] OFF_IO_MAP   = 8'h0C;
  localparam logic [7:0] OFF_DMA_CTRL = 8'h10;
  localparam logic [7:0] OFF_DMA_BASE = 8'h14;
  localparam logic [7:0] WIN_BASE     = 8'h40;
  localparam logic [7:0] WIN_TOP      = 8'(64 + 4 * (MAP_WORDS - 1));

  localparam logic [31:0] CTRL_RSVD_MASK  = 32'h1000_F000;
  localparam logic [31:0] CTRL_PULSE_MASK = 32'h6000_0000;
  localparam logic [31:0] STATUS_RO_MASK  = 32'hFFE0_0FFF;
  localparam logic [31:0] STATUS_W1C_MASK = 32'h001F_F000;
  localparam logic [31:0] IO_MAP_MASK     = 32'hFFFF_0000;
  localparam logic [31:0] DMA_RW_MASK     = 32'h8000_0077;
  localparam logic [31:0] DMA_RO_MASK     = 32'h7FF0_0008;
  localparam logic [31:0] DMA_W1C_MASK    = 32'h000F_FF80;
  localparam logic [31:0] DMA_GUARD_MASK  = 32'h0000_0072;

  localparam logic [31:0] STATUS_RESET   = 32'h5100_0000;
  localparam logic [31:0] DMA_CTRL_RESET = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  offset;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        decode_miss;
    logic        bus_reset_request;
    logic        master_reset_request;
    logic        target_reset_request;
    logic        dma_enable_request;
    logic        dma_disable_request;
  } out_item_t;

endpackage

// ===== rtl/pbrf_regs.sv =====
// register storage, offset decode and per-bit write rules
module pbrf_regs
  import pbrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_vld,
  input  in_item_t  item,
  output out_item_t result
);

  logic [31:0] ctrl_r, ctrl_nxt;
  logic [31:0] status_r, status_nxt;
  logic [31:0] io_map_r, io_map_nxt;
  logic [31:0] dma_ctrl_r, dma_ctrl_nxt;
  logic [31:0] dma_base_r, dma_base_nxt;
  logic [31:0] win_r [MAP_WORDS];

  logic [7:0]           win_off;
  logic                 win_hit;
  logic [WIN_IDX_W-1:0] win_idx;
  logic                 win_we;
  logic [31:0]          ctrl_wr;
  logic [31:0]          dma_wr;
  op_t                  op;

  assign op      = op_t'(item.operation);
  assign win_off = item.offset - WIN_BASE;
  assign win_hit = (item.offset >= WIN_BASE) && (item.offset <= WIN_TOP);
  assign win_idx = win_off[WIN_IDX_W+1:2];
  assign ctrl_wr = item.write_data & ~CTRL_RSVD_MASK;
  // safeguard: without bit 31 the guarded bits are written as zero
  assign dma_wr  = item.write_data[31] ? item.write_data
                                       : (item.write_data & ~DMA_GUARD_MASK);

  always_comb begin
    ctrl_nxt     = ctrl_r;
    status_nxt   = status_r;
    io_map_nxt   = io_map_r;
    dma_ctrl_nxt = dma_ctrl_r;
    dma_base_nxt = dma_base_r;
    win_we       = 1'b0;
    result       = '0;
    if (item_vld) begin
      case (op)
        OP_READ: begin
          case (item.offset)
            OFF_CTRL:     result.read_data = ctrl_r;
            OFF_STATUS:   result.read_data = status_r;
            OFF_IO_MAP:   result.read_data = io_map_r;
            OFF_DMA_CTRL: result.read_data = dma_ctrl_r;
            OFF_DMA_BASE: result.read_data = dma_base_r;
            default: begin
              if (win_hit) begin
                result.read_data = win_r[win_idx];
              end else begin
                result.decode_miss = 1'b1;
              end
            end
          endcase
        end
        OP_WRITE: begin
          case (item.offset)
            OFF_CTRL: begin
              result.bus_reset_request    = ctrl_wr[31];
              result.master_reset_request = ctrl_wr[30];
              result.target_reset_request = ctrl_wr[29];
              ctrl_nxt = ctrl_wr & ~CTRL_PULSE_MASK;
            end
            OFF_STATUS: begin
              status_nxt = (status_r & STATUS_RO_MASK)
                         | (status_r & STATUS_W1C_MASK & ~item.write_data);
            end
            OFF_IO_MAP: io_map_nxt = item.write_data & IO_MAP_MASK;
            OFF_DMA_CTRL: begin
              result.dma_disable_request = item.write_data[2];
              result.dma_enable_request  = item.write_data[0];
              dma_ctrl_nxt = (dma_ctrl_r & DMA_RO_MASK) | (dma_wr & DMA_RW_MASK)
                           | (dma_ctrl_r & DMA_W1C_MASK & ~dma_wr);
            end
            OFF_DMA_BASE: dma_base_nxt = item.write_data;
            default: begin
              if (win_hit) begin
                win_we = 1'b1;
              end else begin
                result.decode_miss = 1'b1;
              end
            end
          endcase
        end
        OP_DONE: begin
          // config access completed: clear bit 19, set bit 20
          status_nxt     = status_r;
          status_nxt[19] = 1'b0;
          status_nxt[20] = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r     <= '0;
      status_r   <= STATUS_RESET;
      io_map_r   <= '0;
      dma_ctrl_r <= DMA_CTRL_RESET;
      dma_base_r <= '0;
      for (int i = 0; i < MAP_WORDS; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      ctrl_r     <= ctrl_nxt;
      status_r   <= status_nxt;
      io_map_r   <= io_map_nxt;
      dma_ctrl_r <= dma_ctrl_nxt;
      dma_base_r <= dma_base_nxt;
      if (win_we) begin
        win_r[win_idx] <= item.write_data;
      end
    end
  end

endmodule

// ===== rtl/pci_bridge_register_file.sv =====
// top level of the bridge register file: command register, register core, result register
// One access is taken in every clock cycle: busy is always low, so an access is
// accepted at each edge where start is high. Its result is on out_item with
// out_strobe high for exactly one cycle (decode and register update happen while the
// access sits in the command register, the result register then holds the result
// for its one cycle). Results come in acceptance order, one per access, and the
// receiver must take them as they come; a read sees every earlier write.
// Completion events and operation code 3 also give a result, with all fields zero.
module pci_bridge_register_file
  import pbrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic      cmd_vld_r, cmd_vld_nxt;
  in_item_t  cmd_r, cmd_nxt;
  logic      res_vld_r, res_vld_nxt;
  out_item_t res_r, res_nxt;
  out_item_t core_res;

  assign busy        = 1'b0;
  assign cmd_vld_nxt = start && !busy;
  assign cmd_nxt     = in_item;
  assign res_vld_nxt = cmd_vld_r;
  assign res_nxt     = core_res;

  pbrf_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (cmd_vld_r),
    .item     (cmd_r),
    .result   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
  end

  assign out_strobe = res_vld_r;
  assign out_item   = res_r;

endmodule

// ===== rtl/pbrf_checker.sv =====
// port-level checks of the bridge register file and their bind
module pbrf_checker
  import pbrf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);

  // every accepted access gives a result once it has passed the command and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("accepted access gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result without an accepted access");

  a_miss_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.decode_miss) |-> (out_item.read_data == '0))
    else $error("decode miss with non-zero read data");

  a_request_groups: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.bus_reset_request || out_item.master_reset_request
      || out_item.target_reset_request))
      |-> (!out_item.dma_enable_request && !out_item.dma_disable_request
           && !out_item.decode_miss && (out_item.read_data == '0)))
    else $error("control and dma requests in one result");

endmodule

bind pci_bridge_register_file pbrf_checker u_pbrf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
